### hdl/sbc_pkg.sv
// Shared constants, register codes and small types of the box clustering block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sbc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 10;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 15;
  localparam int CFG_CNT_BITS  = 10;
  localparam int SQ_BITS       = 2 * CFG_DATA_BITS;
  localparam int DIST_BITS     = 32;
  localparam int REC_DEPTH     = 4;

  localparam int TOLERANCE_RST  = 205;
  localparam int MIN_SIZE_RST   = 246;
  localparam int MAX_SIZE_RST   = 1638;
  localparam int MIN_POINTS_RST = 3;
  localparam int MAX_POINTS_RST = 80;
  localparam int EMERG_DIST_RST = 655;
  localparam int TOL_SQ_RST     = TOLERANCE_RST * TOLERANCE_RST;
  localparam int EMERG_SQ_RST   = EMERG_DIST_RST * EMERG_DIST_RST;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TOLERANCE  = 3'd0,
    CFG_MIN_SIZE   = 3'd1,
    CFG_MAX_SIZE   = 3'd2,
    CFG_MIN_POINTS = 3'd3,
    CFG_MAX_POINTS = 3'd4,
    CFG_EMERG_DIST = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] min_size;
    logic [CFG_DATA_BITS-1:0] max_size;
    logic [CFG_CNT_BITS-1:0]  fewest_pts;
    logic [CFG_CNT_BITS-1:0]  most_pts;
    logic [SQ_BITS-1:0]       emerg_sq;
  } limits_t;

  typedef struct packed {
    logic present;
    logic last;
  } rec_flags_t;

endpackage

`default_nettype wire

### hdl/sbc_if.sv
// Valid/ready channel interfaces for the point input and the box result output.
// Depends on sbc_pkg for the default field widths.
`default_nettype none

interface sbc_in_if import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         has_point;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         scan_end;

  modport source (output valid, has_point, point_x, point_y, scan_end, input ready);
  modport sink   (input valid, has_point, point_x, point_y, scan_end, output ready);
endinterface

interface sbc_out_if import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         box_present;
  logic signed [COORD_BITS-1:0] box_x_low;
  logic signed [COORD_BITS-1:0] box_x_high;
  logic signed [COORD_BITS-1:0] box_y_low;
  logic signed [COORD_BITS-1:0] box_y_high;
  logic [COUNT_BITS-1:0]        box_points;
  logic                         box_accepted;
  logic [DIST_BITS-1:0]         box_distance_sq;
  logic [DIST_BITS-1:0]         nearest_distance_sq;
  logic                         emergency;
  logic                         last_of_scan;

  modport source (output valid, box_present, box_x_low, box_x_high, box_y_low, box_y_high,
                  box_points, box_accepted, box_distance_sq, nearest_distance_sq,
                  emergency, last_of_scan, input ready);
  modport sink   (input valid, box_present, box_x_low, box_x_high, box_y_low, box_y_high,
                  box_points, box_accepted, box_distance_sq, nearest_distance_sq,
                  emergency, last_of_scan, output ready);
endinterface

`default_nettype wire

### hdl/sbc_grow.sv
// Open box register, join test and the small queue of closed box records.
// Depends on sbc_pkg and the input channel interface in sbc_if.sv.
`default_nettype none

module sbc_grow import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sbc_in_if.sink                       in_ch,
  input  logic [SQ_BITS-1:0]           tol_sq,
  input  logic                         head_pop,
  output logic                         head_valid,
  output rec_flags_t                   head_flags,
  output logic signed [COORD_BITS-1:0] head_x_low,
  output logic signed [COORD_BITS-1:0] head_x_high,
  output logic signed [COORD_BITS-1:0] head_y_low,
  output logic signed [COORD_BITS-1:0] head_y_high,
  output logic [COUNT_BITS-1:0]        head_count
);

  localparam int GAP_BITS  = (COORD_BITS + 1 > CFG_DATA_BITS + 1) ? COORD_BITS + 1
                                                                  : CFG_DATA_BITS + 1;
  localparam int PTR_BITS  = $clog2(REC_DEPTH);
  localparam int FILL_BITS = PTR_BITS + 1;

  logic signed [COORD_BITS-1:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic signed [COORD_BITS-1:0] x_low_nxt, x_high_nxt, y_low_nxt, y_high_nxt;
  logic [COUNT_BITS-1:0]        count_r, count_nxt;
  logic                         open_r, open_nxt;

  logic                         fire;
  logic signed [GAP_BITS-1:0]   px_e, py_e, xl_e, xh_e, yl_e, yh_e;
  logic [GAP_BITS-1:0]          gap_x, gap_y;
  logic [SQ_BITS-1:0]           sq_x, sq_y;
  logic [SQ_BITS:0]             gap_sq;
  logic                         near, joins;

  logic                         push_old, push_end, wr0, wr1;
  rec_flags_t                   rec0_flags, end_flags;
  logic signed [COORD_BITS-1:0] rec0_xl, rec0_xh, rec0_yl, rec0_yh;
  logic [COUNT_BITS-1:0]        rec0_cnt;

  rec_flags_t                   q_flags_r [REC_DEPTH];
  logic signed [COORD_BITS-1:0] q_xl_r [REC_DEPTH];
  logic signed [COORD_BITS-1:0] q_xh_r [REC_DEPTH];
  logic signed [COORD_BITS-1:0] q_yl_r [REC_DEPTH];
  logic signed [COORD_BITS-1:0] q_yh_r [REC_DEPTH];
  logic [COUNT_BITS-1:0]        q_cnt_r [REC_DEPTH];
  logic [PTR_BITS-1:0]          head_r, tail_r, tail_inc;
  logic [FILL_BITS-1:0]         fill_r, fill_nxt;

  assign fire = in_ch.valid && in_ch.ready;

  assign px_e = GAP_BITS'(in_ch.point_x);
  assign py_e = GAP_BITS'(in_ch.point_y);
  assign xl_e = GAP_BITS'(x_low_r);
  assign xh_e = GAP_BITS'(x_high_r);
  assign yl_e = GAP_BITS'(y_low_r);
  assign yh_e = GAP_BITS'(y_high_r);

  always_comb begin
    if (px_e < xl_e) begin
      gap_x = xl_e - px_e;
    end else if (px_e > xh_e) begin
      gap_x = px_e - xh_e;
    end else begin
      gap_x = '0;
    end
    if (py_e < yl_e) begin
      gap_y = yl_e - py_e;
    end else if (py_e > yh_e) begin
      gap_y = py_e - yh_e;
    end else begin
      gap_y = '0;
    end
  end

  // A gap at or beyond 2^15 is always past any tolerance, so only 15 bits are squared.
  assign sq_x   = SQ_BITS'(gap_x[CFG_DATA_BITS-1:0]) * SQ_BITS'(gap_x[CFG_DATA_BITS-1:0]);
  assign sq_y   = SQ_BITS'(gap_y[CFG_DATA_BITS-1:0]) * SQ_BITS'(gap_y[CFG_DATA_BITS-1:0]);
  assign gap_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign near   = !(|gap_x[GAP_BITS-1:CFG_DATA_BITS]) && !(|gap_y[GAP_BITS-1:CFG_DATA_BITS])
                  && (gap_sq <= {1'b0, tol_sq});
  assign joins  = open_r && near;

  always_comb begin
    x_low_nxt  = x_low_r;
    x_high_nxt = x_high_r;
    y_low_nxt  = y_low_r;
    y_high_nxt = y_high_r;
    count_nxt  = count_r;
    open_nxt   = open_r;
    if (fire && in_ch.has_point) begin
      if (joins) begin
        if (in_ch.point_x < x_low_r)  x_low_nxt  = in_ch.point_x;
        if (in_ch.point_x > x_high_r) x_high_nxt = in_ch.point_x;
        if (in_ch.point_y < y_low_r)  y_low_nxt  = in_ch.point_y;
        if (in_ch.point_y > y_high_r) y_high_nxt = in_ch.point_y;
        if (!(&count_r)) count_nxt = count_r + 1'b1;
      end else begin
        x_low_nxt  = in_ch.point_x;
        x_high_nxt = in_ch.point_x;
        y_low_nxt  = in_ch.point_y;
        y_high_nxt = in_ch.point_y;
        count_nxt  = COUNT_BITS'(1);
      end
      open_nxt = 1'b1;
    end
    if (fire && in_ch.scan_end) begin
      open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
    end
    x_low_r  <= x_low_nxt;
    x_high_r <= x_high_nxt;
    y_low_r  <= y_low_nxt;
    y_high_r <= y_high_nxt;
    count_r  <= count_nxt;
  end

  assign push_old = fire && in_ch.has_point && open_r && !near;
  assign push_end = fire && in_ch.scan_end;
  assign wr0      = push_old || push_end;
  assign wr1      = push_old && push_end;
  assign tail_inc = tail_r + 1'b1;

  always_comb begin
    end_flags.present = open_r || in_ch.has_point;
    end_flags.last    = 1'b1;
    if (push_old) begin
      rec0_flags.present = 1'b1;
      rec0_flags.last    = 1'b0;
      rec0_xl            = x_low_r;
      rec0_xh            = x_high_r;
      rec0_yl            = y_low_r;
      rec0_yh            = y_high_r;
      rec0_cnt           = count_r;
    end else begin
      rec0_flags = end_flags;
      rec0_xl    = x_low_nxt;
      rec0_xh    = x_high_nxt;
      rec0_yl    = y_low_nxt;
      rec0_yh    = y_high_nxt;
      rec0_cnt   = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      q_flags_r[tail_r] <= rec0_flags;
      q_xl_r[tail_r]    <= rec0_xl;
      q_xh_r[tail_r]    <= rec0_xh;
      q_yl_r[tail_r]    <= rec0_yl;
      q_yh_r[tail_r]    <= rec0_yh;
      q_cnt_r[tail_r]   <= rec0_cnt;
    end
    if (wr1) begin
      q_flags_r[tail_inc] <= end_flags;
      q_xl_r[tail_inc]    <= x_low_nxt;
      q_xh_r[tail_inc]    <= x_high_nxt;
      q_yl_r[tail_inc]    <= y_low_nxt;
      q_yh_r[tail_inc]    <= y_high_nxt;
      q_cnt_r[tail_inc]   <= count_nxt;
    end
  end

  assign fill_nxt = fill_r + FILL_BITS'(wr0) + FILL_BITS'(wr1) - FILL_BITS'(head_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (head_pop) head_r <= head_r + 1'b1;
      if (wr1) begin
        tail_r <= tail_r + 2'd2;
      end else if (wr0) begin
        tail_r <= tail_inc;
      end
    end
  end

  assign in_ch.ready = (fill_r <= FILL_BITS'(REC_DEPTH - 2));
  assign head_valid  = (fill_r != '0);
  assign head_flags  = q_flags_r[head_r];
  assign head_x_low  = q_xl_r[head_r];
  assign head_x_high = q_xh_r[head_r];
  assign head_y_low  = q_yl_r[head_r];
  assign head_y_high = q_yh_r[head_r];
  assign head_count  = q_cnt_r[head_r];

endmodule

`default_nettype wire

### hdl/sbc_eval.sv
// Accept test, nearest-point distance and running scan minimum for closed boxes.
// Depends on sbc_pkg and the result channel interface in sbc_if.sv.
`default_nettype none

module sbc_eval import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  limits_t                      limits,
  input  logic                         head_valid,
  input  rec_flags_t                   head_flags,
  input  logic signed [COORD_BITS-1:0] head_x_low,
  input  logic signed [COORD_BITS-1:0] head_x_high,
  input  logic signed [COORD_BITS-1:0] head_y_low,
  input  logic signed [COORD_BITS-1:0] head_y_high,
  input  logic [COUNT_BITS-1:0]        head_count,
  output logic                         head_pop,
  sbc_out_if.source                    out_ch
);

  localparam int SIZE_BITS = (COORD_BITS > CFG_DATA_BITS) ? COORD_BITS : CFG_DATA_BITS;
  localparam int PCNT_BITS = (COUNT_BITS > CFG_CNT_BITS) ? COUNT_BITS : CFG_CNT_BITS;
  localparam int PROD_BITS = 2 * COORD_BITS;
  localparam int SUM_BITS  = (PROD_BITS + 1 > DIST_BITS + 1) ? PROD_BITS + 1 : DIST_BITS + 1;

  logic                   s2_load, s3_load;
  logic                   present;
  logic [COORD_BITS-1:0]  ext_x, ext_y;
  logic [SIZE_BITS-1:0]   len_w, wid_w, min_sz, max_sz;
  logic [PCNT_BITS-1:0]   cnt_w, min_pt, max_pt;
  logic                   acc;
  logic [COORD_BITS-1:0]  nx, ny, mag_x, mag_y;
  logic [PROD_BITS-1:0]   sq_x, sq_y;

  logic                         s2_v_r, s2_acc_r;
  rec_flags_t                   s2_flags_r;
  logic signed [COORD_BITS-1:0] s2_xl_r, s2_xh_r, s2_yl_r, s2_yh_r;
  logic [COUNT_BITS-1:0]        s2_cnt_r;
  logic [PROD_BITS-1:0]         s2_sqx_r, s2_sqy_r;

  logic [SUM_BITS-1:0]    dist_sum;
  logic [DIST_BITS-1:0]   dist_sat, near_new;
  logic                   closer, alarm, emerg_new;
  logic [DIST_BITS-1:0]   nearest_r;
  logic                   emerg_r;

  logic                         out_v_r, out_present_r, out_acc_r, out_emerg_r, out_last_r;
  logic signed [COORD_BITS-1:0] out_xl_r, out_xh_r, out_yl_r, out_yh_r;
  logic [COUNT_BITS-1:0]        out_cnt_r;
  logic [DIST_BITS-1:0]         out_dist_r, out_near_r;

  assign s3_load  = !out_v_r || out_ch.ready;
  assign s2_load  = !s2_v_r || s3_load;
  assign head_pop = head_valid && s2_load;

  assign present = head_flags.present;
  assign ext_x   = head_x_high - head_x_low;
  assign ext_y   = head_y_high - head_y_low;
  assign len_w   = SIZE_BITS'(ext_x);
  assign wid_w   = SIZE_BITS'(ext_y);
  assign min_sz  = SIZE_BITS'(limits.min_size);
  assign max_sz  = SIZE_BITS'(limits.max_size);
  assign cnt_w   = PCNT_BITS'(head_count);
  assign min_pt  = PCNT_BITS'(limits.fewest_pts);
  assign max_pt  = PCNT_BITS'(limits.most_pts);
  assign acc     = present && (wid_w >= min_sz || len_w >= min_sz) && cnt_w >= min_pt
                   && wid_w <= max_sz && len_w <= max_sz && cnt_w <= max_pt;

  always_comb begin
    if (!head_x_low[COORD_BITS-1] && (|head_x_low)) begin
      nx = head_x_low;
    end else if (head_x_high[COORD_BITS-1]) begin
      nx = head_x_high;
    end else begin
      nx = '0;
    end
    if (!head_y_low[COORD_BITS-1] && (|head_y_low)) begin
      ny = head_y_low;
    end else if (head_y_high[COORD_BITS-1]) begin
      ny = head_y_high;
    end else begin
      ny = '0;
    end
  end

  assign mag_x = nx[COORD_BITS-1] ? (~nx + 1'b1) : nx;
  assign mag_y = ny[COORD_BITS-1] ? (~ny + 1'b1) : ny;
  assign sq_x  = PROD_BITS'(mag_x) * PROD_BITS'(mag_x);
  assign sq_y  = PROD_BITS'(mag_y) * PROD_BITS'(mag_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= head_valid;
    end
    if (head_pop) begin
      s2_flags_r <= head_flags;
      s2_acc_r   <= acc;
      s2_xl_r    <= present ? head_x_low : '0;
      s2_xh_r    <= present ? head_x_high : '0;
      s2_yl_r    <= present ? head_y_low : '0;
      s2_yh_r    <= present ? head_y_high : '0;
      s2_cnt_r   <= present ? head_count : '0;
      s2_sqx_r   <= present ? sq_x : '0;
      s2_sqy_r   <= present ? sq_y : '0;
    end
  end

  assign dist_sum  = SUM_BITS'(s2_sqx_r) + SUM_BITS'(s2_sqy_r);
  assign dist_sat  = (|dist_sum[SUM_BITS-1:DIST_BITS]) ? '1 : dist_sum[DIST_BITS-1:0];
  assign closer    = s2_acc_r && (dist_sat < nearest_r);
  assign alarm     = s2_acc_r && (dist_sat < DIST_BITS'(limits.emerg_sq));
  assign near_new  = closer ? dist_sat : nearest_r;
  assign emerg_new = emerg_r || alarm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r   <= 1'b0;
      nearest_r <= '1;
      emerg_r   <= 1'b0;
    end else begin
      if (s3_load) out_v_r <= s2_v_r;
      if (s3_load && s2_v_r) begin
        nearest_r <= s2_flags_r.last ? '1 : near_new;
        emerg_r   <= s2_flags_r.last ? 1'b0 : emerg_new;
      end
    end
    if (s3_load && s2_v_r) begin
      out_present_r <= s2_flags_r.present;
      out_last_r    <= s2_flags_r.last;
      out_acc_r     <= s2_acc_r;
      out_xl_r      <= s2_xl_r;
      out_xh_r      <= s2_xh_r;
      out_yl_r      <= s2_yl_r;
      out_yh_r      <= s2_yh_r;
      out_cnt_r     <= s2_cnt_r;
      out_dist_r    <= dist_sat;
      out_near_r    <= near_new;
      out_emerg_r   <= emerg_new;
    end
  end

  assign out_ch.valid               = out_v_r;
  assign out_ch.box_present         = out_present_r;
  assign out_ch.box_x_low           = out_xl_r;
  assign out_ch.box_x_high          = out_xh_r;
  assign out_ch.box_y_low           = out_yl_r;
  assign out_ch.box_y_high          = out_yh_r;
  assign out_ch.box_points          = out_cnt_r;
  assign out_ch.box_accepted        = out_acc_r;
  assign out_ch.box_distance_sq     = out_dist_r;
  assign out_ch.nearest_distance_sq = out_near_r;
  assign out_ch.emergency           = out_emerg_r;
  assign out_ch.last_of_scan        = out_last_r;

endmodule

`default_nettype wire

### hdl/sequential_box_clustering_top.sv
// Top level of the sequential box clustering block: configuration registers and the two stages.
// Depends on sbc_pkg, sbc_if.sv, sbc_grow and sbc_eval.
//
//   channel  direction  handshake          beat
//   in_ch    sink       valid / ready      one scan point or a bare scan end marker
//   out_ch   source     valid / ready      one closed box or an empty end-of-scan record
//   cfg_*    sink       cfg_we only        one register write, index and data
//
// One input beat is taken per cycle while in_ch.ready is high; the open box is updated in the
// cycle the beat is accepted. A result passes the record queue, the s2 register and the output
// register; a beat that closes a box and ends the scan yields two results.
// Reset is synchronous and clears the box, the record queue, the scan minimum and the flags.
// in_ch.ready follows the fill of the four-entry record queue: it drops while three or more
// records wait, as when out_ch.ready has been low long enough to fill it.
`default_nettype none

module sequential_box_clustering_top import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  sbc_in_if.sink                   in_ch,
  sbc_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [SQ_BITS-1:0]           tol_sq_r, data_sq;
  limits_t                      lim_r;

  logic                         head_valid, head_pop;
  rec_flags_t                   head_flags;
  logic signed [COORD_BITS-1:0] head_x_low, head_x_high, head_y_low, head_y_high;
  logic [COUNT_BITS-1:0]        head_count;

  assign data_sq = SQ_BITS'(cfg_data) * SQ_BITS'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_sq_r         <= SQ_BITS'(TOL_SQ_RST);
      lim_r.min_size   <= CFG_DATA_BITS'(MIN_SIZE_RST);
      lim_r.max_size   <= CFG_DATA_BITS'(MAX_SIZE_RST);
      lim_r.fewest_pts <= CFG_CNT_BITS'(MIN_POINTS_RST);
      lim_r.most_pts   <= CFG_CNT_BITS'(MAX_POINTS_RST);
      lim_r.emerg_sq   <= SQ_BITS'(EMERG_SQ_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TOLERANCE:  tol_sq_r         <= data_sq;
        CFG_MIN_SIZE:   lim_r.min_size   <= cfg_data;
        CFG_MAX_SIZE:   lim_r.max_size   <= cfg_data;
        CFG_MIN_POINTS: lim_r.fewest_pts <= cfg_data[CFG_CNT_BITS-1:0];
        CFG_MAX_POINTS: lim_r.most_pts   <= cfg_data[CFG_CNT_BITS-1:0];
        CFG_EMERG_DIST: lim_r.emerg_sq   <= data_sq;
        default: ;
      endcase
    end
  end

  sbc_grow #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_grow (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .tol_sq      (tol_sq_r),
    .head_pop    (head_pop),
    .head_valid  (head_valid),
    .head_flags  (head_flags),
    .head_x_low  (head_x_low),
    .head_x_high (head_x_high),
    .head_y_low  (head_y_low),
    .head_y_high (head_y_high),
    .head_count  (head_count)
  );

  sbc_eval #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .limits      (lim_r),
    .head_valid  (head_valid),
    .head_flags  (head_flags),
    .head_x_low  (head_x_low),
    .head_x_high (head_x_high),
    .head_y_low  (head_y_low),
    .head_y_high (head_y_high),
    .head_count  (head_count),
    .head_pop    (head_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
